// ----- hw/rtl/dhtfd_pkg.sv -----
package dhtfd_pkg;

  localparam int unsigned CFG_W       = 10;
  localparam int unsigned DUR_W       = 16;
  localparam int unsigned FRAME_BITS  = 40;
  localparam int unsigned BITCNT_W    = 6;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_EDGE    = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_NO_START_FALL  = 3'd1;
  localparam logic [2:0] ST_BAD_RESP_LOW   = 3'd2;
  localparam logic [2:0] ST_RESP_TIMEOUT   = 3'd3;
  localparam logic [2:0] ST_SHORT_HIGH     = 3'd4;
  localparam logic [2:0] ST_BIT_TIMEOUT    = 3'd5;
  localparam logic [2:0] ST_BIT_ERROR      = 3'd6;
  localparam logic [2:0] ST_CHECKSUM       = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW_MIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW_MAX      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH_ABOVE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_LOW_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_HIGH_MIN = 3'd4;

  localparam logic [CFG_W-1:0] RST_SYNC_LOW_MIN      = 10'd25;
  localparam logic [CFG_W-1:0] RST_SYNC_LOW_MAX      = 10'd75;
  localparam logic [CFG_W-1:0] RST_ONE_HIGH_ABOVE    = 10'd50;
  localparam logic [CFG_W-1:0] RST_RESPONSE_LOW_MIN  = 10'd60;
  localparam logic [CFG_W-1:0] RST_RESPONSE_HIGH_MIN = 10'd65;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'b00001,
    PH_START_FALL = 5'b00010,
    PH_RESP_LOW   = 5'b00100,
    PH_RESP_HIGH  = 5'b01000,
    PH_DATA       = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] sync_low_min;
    logic [CFG_W-1:0] sync_low_max;
    logic [CFG_W-1:0] one_high_above;
    logic [CFG_W-1:0] response_low_min;
    logic [CFG_W-1:0] response_high_min;
  } cfg_t;

endpackage

// ----- hw/rtl/dhtfd_cfg.sv -----
module dhtfd_cfg
  import dhtfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_SYNC_LOW_MIN:      cfg_nxt.sync_low_min      = wr_data;
        REG_SYNC_LOW_MAX:      cfg_nxt.sync_low_max      = wr_data;
        REG_ONE_HIGH_ABOVE:    cfg_nxt.one_high_above    = wr_data;
        REG_RESPONSE_LOW_MIN:  cfg_nxt.response_low_min  = wr_data;
        REG_RESPONSE_HIGH_MIN: cfg_nxt.response_high_min = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_low_min      <= RST_SYNC_LOW_MIN;
      cfg_r.sync_low_max      <= RST_SYNC_LOW_MAX;
      cfg_r.one_high_above    <= RST_ONE_HIGH_ABOVE;
      cfg_r.response_low_min  <= RST_RESPONSE_LOW_MIN;
      cfg_r.response_high_min <= RST_RESPONSE_HIGH_MIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/dht22_frame_decoder.sv -----
// Decodes one single-wire humidity/temperature sensor frame from line events
// (start, timed edge, timeout). Takes one event per clock while in_stall is low; an
// event enters an input register and is decoded against the frame state once the
// result register can advance, and a transaction that completes or aborts a frame
// loads the result register, which drives out_valid. The input side stalls only
// while the output register holds an untaken result and out_stall is high. Config
// registers are always ready and should be written only while idle; unknown
// indexes are ignored. Humidity and temperature read zero on error status.
module dht22_frame_decoder
  import dhtfd_pkg::*;
#(
  parameter int DURATION_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_func,
  input  logic                 in_line_was_high,
  input  logic [DUR_W-1:0]     in_duration_us,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic [15:0]          out_humidity_tenths,
  output logic signed [15:0]   out_temperature_tenths,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam logic [DUR_W-1:0] DUR_MASK = (DURATION_WIDTH >= DUR_W) ? {DUR_W{1'b1}} :
                                          DUR_W'((64'd1 << DURATION_WIDTH) - 64'd1);

  cfg_t cfg;

  // input register
  logic             s1_valid_r, s1_valid_nxt;
  logic [1:0]       s1_func_r;
  logic             s1_high_r;
  logic [DUR_W-1:0] s1_dur_r;

  // frame state
  phase_t                 phase_r, phase_nxt;
  logic [BITCNT_W-1:0]    bit_count_r, bit_count_nxt;
  logic                   expect_high_r, expect_high_nxt;
  logic [FRAME_BITS-1:0]  frame_r, frame_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic [2:0]             status_r;
  logic [15:0]            hum_r;
  logic [15:0]            temp_r;

  logic                   advance;
  logic                   fire;
  logic                   in_take;
  logic                   emit;
  logic [2:0]             emit_status;
  logic [15:0]            emit_hum;
  logic [15:0]            emit_temp;
  logic                   timeout;
  logic [FRAME_BITS-1:0]  shifted;
  logic [BITCNT_W-1:0]    count_inc;
  logic [7:0]             b0, b1, b2, b3, b4;
  logic [7:0]             sum;
  logic [15:0]            mag;

  dhtfd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  assign cfg_ready = 1'b1;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take)      s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
  end

  assign timeout   = (s1_func_r == FUNC_TIMEOUT);
  assign shifted   = {frame_r[FRAME_BITS-2:0],
                      (s1_dur_r > DUR_W'(cfg.one_high_above))};
  assign count_inc = bit_count_r + BITCNT_W'(1);

  // checksum and temperature decode on the frame including the last bit
  assign b0  = shifted[39:32];
  assign b1  = shifted[31:24];
  assign b2  = shifted[23:16];
  assign b3  = shifted[15:8];
  assign b4  = shifted[7:0];
  assign sum = b0 + b1 + b2 + b3;
  assign mag = {1'b0, b2[6:0], b3};

  always_comb begin
    phase_nxt       = phase_r;
    bit_count_nxt   = bit_count_r;
    expect_high_nxt = expect_high_r;
    frame_nxt       = frame_r;
    emit            = 1'b0;
    emit_status     = ST_OK;
    emit_hum        = '0;
    emit_temp       = '0;

    if (fire) begin
      if (s1_func_r == FUNC_START) begin
        phase_nxt       = PH_START_FALL;
        bit_count_nxt   = '0;
        expect_high_nxt = 1'b0;
        frame_nxt       = '0;
      end else if (s1_func_r == FUNC_EDGE || timeout) begin
        case (phase_r)
          PH_START_FALL: begin
            if (timeout || !s1_high_r || s1_dur_r == '0) begin
              emit = 1'b1; emit_status = ST_NO_START_FALL;
            end else begin
              phase_nxt = PH_RESP_LOW;
            end
          end
          PH_RESP_LOW: begin
            if (timeout || s1_high_r || s1_dur_r < DUR_W'(cfg.response_low_min)) begin
              emit = 1'b1; emit_status = ST_BAD_RESP_LOW;
            end else begin
              phase_nxt = PH_RESP_HIGH;
            end
          end
          PH_RESP_HIGH: begin
            if (timeout) begin
              emit = 1'b1; emit_status = ST_RESP_TIMEOUT;
            end else if (!s1_high_r || s1_dur_r < DUR_W'(cfg.response_high_min)) begin
              emit = 1'b1; emit_status = ST_SHORT_HIGH;
            end else begin
              phase_nxt       = PH_DATA;
              bit_count_nxt   = '0;
              expect_high_nxt = 1'b0;
              frame_nxt       = '0;
            end
          end
          PH_DATA: begin
            if (!expect_high_r) begin
              if (timeout) begin
                emit = 1'b1; emit_status = ST_BIT_TIMEOUT;
              end else if (s1_high_r || s1_dur_r < DUR_W'(cfg.sync_low_min) ||
                           s1_dur_r > DUR_W'(cfg.sync_low_max)) begin
                emit = 1'b1; emit_status = ST_BIT_ERROR;
              end else begin
                expect_high_nxt = 1'b1;
              end
            end else if (timeout || !s1_high_r) begin
              emit = 1'b1; emit_status = ST_BIT_ERROR;
            end else begin
              frame_nxt       = shifted;
              expect_high_nxt = 1'b0;
              bit_count_nxt   = count_inc;
              if (count_inc >= BITCNT_W'(FRAME_BITS)) begin
                emit = 1'b1;
                if (sum != b4) begin
                  emit_status = ST_CHECKSUM;
                end else begin
                  emit_status = ST_OK;
                  emit_hum    = {b0, b1};
                  emit_temp   = b2[7] ? (16'd0 - mag) : mag;
                end
              end
            end
          end
          default: ;
        endcase
        if (emit) begin
          phase_nxt       = PH_IDLE;
          bit_count_nxt   = '0;
          expect_high_nxt = 1'b0;
          frame_nxt       = '0;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = fire && emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      phase_r       <= PH_IDLE;
      bit_count_r   <= '0;
      expect_high_r <= 1'b0;
      frame_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      phase_r       <= phase_nxt;
      bit_count_r   <= bit_count_nxt;
      expect_high_r <= expect_high_nxt;
      frame_r       <= frame_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r <= in_func;
      s1_high_r <= in_line_was_high;
      s1_dur_r  <= in_duration_us & DUR_MASK;
    end
    if (fire && emit) begin
      status_r <= emit_status;
      hum_r    <= emit_hum;
      temp_r   <= emit_temp;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = status_r;
  assign out_humidity_tenths    = hum_r;
  assign out_temperature_tenths = temp_r;

  a_err_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_humidity_tenths == 16'd0 && out_temperature_tenths == 16'sd0)
    else $error("error result carries nonzero payload");

  a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r < BITCNT_W'(FRAME_BITS))
    else $error("bit count past frame length");

  a_bits_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    (expect_high_r || bit_count_r != '0) |-> phase_r == PH_DATA)
    else $error("bit state outside data phase");

  a_result_needs_event: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_valid_r))
    else $error("result without a decoded transaction");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import dhtfd_pkg::*;

  localparam int         CYCLE_LIMIT    = 600000;
  localparam int         RANDOM_ITEMS   = 160;
  localparam int         RANDOM_PHASES  = 7;
  localparam int         MAX_REPORTS    = 10;
  localparam int         FRAME_EVENTS   = 4 + 2 * FRAME_BITS;
  localparam int         DUR_MAX        = (1 << DUR_W) - 1;
  localparam logic [1:0] FUNC_UNUSED    = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] humidity;
    logic [15:0] temperature;
  } reading_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_func;
  logic                 in_line_was_high;
  logic [DUR_W-1:0]     in_duration_us;
  logic                 out_valid;
  logic                 out_stall;
  logic [2:0]           out_status;
  logic [15:0]          out_humidity_tenths;
  logic signed [15:0]   out_temperature_tenths;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  dht22_frame_decoder uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_func                (in_func),
    .in_line_was_high       (in_line_was_high),
    .in_duration_us         (in_duration_us),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_humidity_tenths    (out_humidity_tenths),
    .out_temperature_tenths (out_temperature_tenths),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  // decoder shadow state
  cfg_t             timing;
  phase_t           frame_phase;
  logic [5:0]       bits_taken;
  logic             want_data_high;
  logic [39:0]      frame_shift;
  reading_t         pending_readings[$];

  int  error_count;
  int  report_count;
  int  cycle_count;
  int  live_events;
  int  hold_cycles;
  bit  src_pauses;
  bit  sink_pauses;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver back-pressure; a requested hold-off takes priority
  initial begin : sink_driver
    int run;
    run = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall = 1'b1;
        hold_cycles--;
      end else if (run > 0) begin
        out_stall = 1'b1;
        run--;
      end else if (sink_pauses && $urandom_range(99, 0) < 30) begin
        out_stall = 1'b1;
        run = ($urandom_range(19, 0) == 0) ? $urandom_range(60, 15) : $urandom_range(2, 0);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin : reading_checker
    reading_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_readings.size() == 0) begin
        error_count++;
        report_count++;
        if (report_count <= MAX_REPORTS)
          $display("%0t: unexpected reading status %0d hum %0d temp %0d", $time,
                   out_status, out_humidity_tenths, out_temperature_tenths);
      end else begin
        want = pending_readings.pop_front();
        if (out_status !== want.status || out_humidity_tenths !== want.humidity ||
            out_temperature_tenths !== want.temperature) begin
          error_count++;
          report_count++;
          if (report_count <= MAX_REPORTS)
            $display("%0t: reading mismatch, expected status %0d hum %0d temp %0d,",
                     $time, want.status, want.humidity, $signed(want.temperature),
                     " got status %0d hum %0d temp %0d",
                     out_status, out_humidity_tenths, out_temperature_tenths);
        end
      end
    end
  end

  function automatic void clear_frame();
    bits_taken     = '0;
    want_data_high = 1'b0;
    frame_shift    = '0;
  endfunction

  // returns 1 when the event ends a frame, with the reading it produces
  function automatic bit predict_reading(input logic [1:0] fn, input logic hi,
                                         input logic [DUR_W-1:0] d, output reading_t r);
    logic        tmo;
    bit          done;
    logic [7:0]  b0, b1, b2, b3, sum;
    logic [15:0] mag;
    tmo  = (fn == FUNC_TIMEOUT);
    done = 1'b0;
    r    = '0;
    if (fn == FUNC_START) begin
      frame_phase = PH_START_FALL;
      clear_frame();
      return 1'b0;
    end
    if (fn == FUNC_UNUSED || frame_phase == PH_IDLE)
      return 1'b0;
    case (frame_phase)
      PH_START_FALL: begin
        if (tmo || !hi || d == 0) begin
          done = 1'b1;
          r.status = ST_NO_START_FALL;
        end else begin
          frame_phase = PH_RESP_LOW;
        end
      end
      PH_RESP_LOW: begin
        if (tmo || hi || d < timing.response_low_min) begin
          done = 1'b1;
          r.status = ST_BAD_RESP_LOW;
        end else begin
          frame_phase = PH_RESP_HIGH;
        end
      end
      PH_RESP_HIGH: begin
        if (tmo) begin
          done = 1'b1;
          r.status = ST_RESP_TIMEOUT;
        end else if (!hi || d < timing.response_high_min) begin
          done = 1'b1;
          r.status = ST_SHORT_HIGH;
        end else begin
          frame_phase = PH_DATA;
          clear_frame();
        end
      end
      PH_DATA: begin
        if (!want_data_high) begin
          if (tmo) begin
            done = 1'b1;
            r.status = ST_BIT_TIMEOUT;
          end else if (hi || d < timing.sync_low_min || d > timing.sync_low_max) begin
            done = 1'b1;
            r.status = ST_BIT_ERROR;
          end else begin
            want_data_high = 1'b1;
          end
        end else if (tmo || !hi) begin
          done = 1'b1;
          r.status = ST_BIT_ERROR;
        end else begin
          frame_shift    = {frame_shift[38:0], d > timing.one_high_above};
          want_data_high = 1'b0;
          bits_taken     = bits_taken + 1'b1;
          if (bits_taken == FRAME_BITS) begin
            done = 1'b1;
            b0  = frame_shift[39:32];
            b1  = frame_shift[31:24];
            b2  = frame_shift[23:16];
            b3  = frame_shift[15:8];
            sum = b0 + b1 + b2 + b3;
            if (sum != frame_shift[7:0]) begin
              r.status = ST_CHECKSUM;
            end else begin
              // sign-magnitude temperature, bit 7 of the high byte is the sign
              mag           = {1'b0, b2[6:0], b3};
              r.status      = ST_OK;
              r.humidity    = {b0, b1};
              r.temperature = b2[7] ? (16'd0 - mag) : mag;
            end
          end
        end
      end
      default: begin
        frame_phase = PH_IDLE;
        clear_frame();
      end
    endcase
    if (done) begin
      frame_phase = PH_IDLE;
      clear_frame();
    end
    return done;
  endfunction

  function automatic int pick_gap(input bit enabled);
    int n;
    if (!enabled)
      return 0;
    n = $urandom_range(99, 0);
    if (n < 60)
      return 0;
    if (n < 95)
      return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // biased toward the ends of the range so thresholds get hit exactly
  function automatic logic [DUR_W-1:0] dur_between(input int lo, input int hi);
    int n;
    if (hi < lo)
      return DUR_W'(lo);
    n = $urandom_range(3, 0);
    if (n == 0)
      return DUR_W'(lo);
    if (n == 1)
      return DUR_W'(hi);
    return DUR_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic [39:0] build_frame(input logic [31:0] payload, input bit good_sum);
    logic [7:0] sum;
    sum = payload[31:24] + payload[23:16] + payload[15:8] + payload[7:0];
    return {payload, good_sum ? sum : 8'($urandom)};
  endfunction

  task automatic send_event(input logic [1:0] fn, input logic hi, input logic [DUR_W-1:0] d);
    int       gap;
    reading_t r;
    gap = pick_gap(src_pauses);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         = 1'b1;
    in_func          = fn;
    in_line_was_high = hi;
    in_duration_us   = d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!(fn == FUNC_UNUSED || (frame_phase == PH_IDLE && fn != FUNC_START)))
      live_events++;
    if (predict_reading(fn, hi, d, r))
      pending_readings.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SYNC_LOW_MIN:      timing.sync_low_min      = val;
      REG_SYNC_LOW_MAX:      timing.sync_low_max      = val;
      REG_ONE_HIGH_ABOVE:    timing.one_high_above    = val;
      REG_RESPONSE_LOW_MIN:  timing.response_low_min  = val;
      REG_RESPONSE_HIGH_MIN: timing.response_high_min = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // abort any open frame, then let every result drain out of the pipeline
  task automatic settle();
    if (frame_phase != PH_IDLE)
      send_event(FUNC_TIMEOUT, 1'($urandom_range(1, 0)), DUR_W'($urandom));
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic program_timing(input int slm, input int slx, input int oha,
                                input int rlm, input int rhm);
    settle();
    write_reg(REG_SYNC_LOW_MIN, CFG_W'(slm));
    write_reg(REG_SYNC_LOW_MAX, CFG_W'(slx));
    write_reg(REG_ONE_HIGH_ABOVE, CFG_W'(oha));
    write_reg(REG_RESPONSE_LOW_MIN, CFG_W'(rlm));
    write_reg(REG_RESPONSE_HIGH_MIN, CFG_W'(rhm));
  endtask

  // start plus a preamble sitting exactly on the minimum lengths
  task automatic send_preamble();
    send_event(FUNC_START, 1'b0, '0);
    send_event(FUNC_EDGE, 1'b1, 16'd1);
    send_event(FUNC_EDGE, 1'b0, DUR_W'(timing.response_low_min));
    send_event(FUNC_EDGE, 1'b1, DUR_W'(timing.response_high_min));
  endtask

  // corrupt_at < 0 sends a clean frame
  task automatic send_frame(input logic [39:0] data, input int corrupt_at);
    logic [1:0]       fn;
    logic             hi;
    logic [DUR_W-1:0] d;
    for (int k = 0; k < FRAME_EVENTS; k++) begin
      if (k == corrupt_at) begin
        send_event(2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)), DUR_W'($urandom));
        if ($urandom_range(1, 0))
          return;
        continue;
      end
      fn = FUNC_EDGE;
      if (k == 0) begin
        fn = FUNC_START;
        hi = 1'($urandom_range(1, 0));
        d  = DUR_W'($urandom);
      end else if (k == 1) begin
        hi = 1'b1;
        d  = dur_between(1, DUR_MAX);
      end else if (k == 2) begin
        hi = 1'b0;
        d  = dur_between(int'(timing.response_low_min), DUR_MAX);
      end else if (k == 3) begin
        hi = 1'b1;
        d  = dur_between(int'(timing.response_high_min), DUR_MAX);
      end else if (k % 2 == 0) begin
        hi = 1'b0;
        d  = dur_between(int'(timing.sync_low_min), int'(timing.sync_low_max));
      end else begin
        hi = 1'b1;
        if (data[39 - (k - 5) / 2])
          d = dur_between(int'(timing.one_high_above) + 1, DUR_MAX);
        else
          d = dur_between(0, int'(timing.one_high_above));
      end
      send_event(fn, hi, d);
    end
  endtask

  task automatic random_burst();
    int pick;
    int n;
    pick = $urandom_range(99, 0);
    if (pick < 60) begin
      send_frame(build_frame($urandom, $urandom_range(4, 0) != 0), -1);
    end else if (pick < 85) begin
      // early breaks are the interesting ones, so favor them
      n = $urandom_range(1, 0) ? $urandom_range(9, 0) : $urandom_range(FRAME_EVENTS - 1, 0);
      send_frame(build_frame($urandom, 1'b1), n);
    end else begin
      n = $urandom_range(8, 1);
      repeat (n)
        send_event(2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)), DUR_W'($urandom));
    end
  endtask

  task automatic test_ignored_events();
    send_event(FUNC_EDGE, 1'b1, 16'hffff);
    send_event(FUNC_TIMEOUT, 1'b0, 16'h0000);
    send_event(FUNC_UNUSED, 1'b1, 16'h5a5a);
    settle();
  endtask

  task automatic test_preamble_errors();
    send_event(FUNC_START, 1'b0, '0);
    send_event(FUNC_EDGE, 1'b1, 16'd0);
    send_event(FUNC_START, 1'b1, 16'hffff);
    send_event(FUNC_EDGE, 1'b0, 16'd100);
    send_event(FUNC_START, 1'b0, '0);
    send_event(FUNC_UNUSED, 1'b1, 16'd1);
    send_event(FUNC_EDGE, 1'b1, 16'hffff);
    send_event(FUNC_EDGE, 1'b0, DUR_W'(timing.response_low_min - 1));
    send_event(FUNC_START, 1'b0, '0);
    send_event(FUNC_EDGE, 1'b1, 16'd1);
    send_event(FUNC_EDGE, 1'b0, DUR_W'(timing.response_low_min));
    send_event(FUNC_TIMEOUT, 1'b1, 16'd7);
    send_event(FUNC_START, 1'b0, '0);
    send_event(FUNC_EDGE, 1'b1, 16'd1);
    send_event(FUNC_EDGE, 1'b0, 16'hffff);
    send_event(FUNC_EDGE, 1'b1, DUR_W'(timing.response_high_min - 1));
    settle();
  endtask

  task automatic test_bit_errors();
    // restart mid-preamble, then a timeout waiting for the first sync low
    send_event(FUNC_START, 1'b0, '0);
    send_event(FUNC_EDGE, 1'b1, 16'd1);
    send_preamble();
    send_event(FUNC_TIMEOUT, 1'b0, '0);
    send_preamble();
    send_event(FUNC_EDGE, 1'b0, DUR_W'(timing.sync_low_max + 1));
    send_preamble();
    send_event(FUNC_EDGE, 1'b0, DUR_W'(timing.sync_low_min));
    send_event(FUNC_EDGE, 1'b1, 16'd0);
    send_event(FUNC_EDGE, 1'b0, DUR_W'(timing.sync_low_max));
    send_event(FUNC_EDGE, 1'b0, DUR_W'(timing.sync_low_min));
    settle();
  endtask

  task automatic test_frame_values();
    logic [31:0] neg_max;
    neg_max = 32'hffff_ffff;
    send_frame(build_frame(32'h0000_0000, 1'b1), -1);
    send_frame(build_frame(neg_max, 1'b1), -1);
    send_frame(build_frame(32'h0123_8000, 1'b1), -1);
    send_frame(build_frame(32'h0222_7fff, 1'b1), -1);
    send_frame({32'h0100_00f0, 8'hf0}, -1);
    settle();
  endtask

  // long receiver hold-off while the sender keeps pushing aborted frames
  task automatic test_backpressure();
    src_pauses = 1'b0;
    hold_cycles = 300;
    repeat (25) begin
      send_event(FUNC_START, 1'($urandom_range(1, 0)), DUR_W'($urandom));
      send_event(FUNC_TIMEOUT, 1'($urandom_range(1, 0)), DUR_W'($urandom));
    end
    settle();
  endtask

  task automatic test_random_traffic();
    int phase_start;
    int a;
    int b;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      a = $urandom_range(1023, 0);
      b = $urandom_range(1023, 0);
      case (p)
        0: ;
        1: program_timing(0, 0, 0, 0, 0);
        2: program_timing(1023, 1023, 1023, 1023, 1023);
        3: program_timing(a < b ? a : b, a < b ? b : a, $urandom_range(1023, 0),
                          $urandom_range(1023, 0), $urandom_range(1023, 0));
        4: program_timing($urandom_range(1023, 0), $urandom_range(1023, 0),
                          $urandom_range(1023, 0), $urandom_range(1023, 0),
                          $urandom_range(1023, 0));
        5: program_timing(a < b ? a : b, a < b ? b : a, $urandom_range(60, 0),
                          $urandom_range(90, 0), $urandom_range(90, 0));
        default: program_timing(int'(RST_SYNC_LOW_MIN), int'(RST_SYNC_LOW_MAX),
                                int'(RST_ONE_HIGH_ABOVE), int'(RST_RESPONSE_LOW_MIN),
                                int'(RST_RESPONSE_HIGH_MIN));
      endcase
      src_pauses  = (p != 0) && (p % 3 != 1);
      sink_pauses = (p != 0) && (p % 3 != 2);
      phase_start = live_events;
      while (live_events - phase_start < RANDOM_ITEMS / RANDOM_PHASES)
        random_burst();
    end
    src_pauses  = 1'b1;
    sink_pauses = 1'b1;
    settle();
  endtask

  initial begin : main_sequence
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_func            = FUNC_START;
    in_line_was_high   = 1'b0;
    in_duration_us     = '0;
    cfg_valid          = 1'b0;
    cfg_index          = REG_SYNC_LOW_MIN;
    cfg_wdata          = '0;
    error_count        = 0;
    report_count       = 0;
    cycle_count        = 0;
    live_events        = 0;
    hold_cycles        = 0;
    src_pauses         = 1'b0;
    sink_pauses        = 1'b0;
    timing.sync_low_min      = RST_SYNC_LOW_MIN;
    timing.sync_low_max      = RST_SYNC_LOW_MAX;
    timing.one_high_above    = RST_ONE_HIGH_ABOVE;
    timing.response_low_min  = RST_RESPONSE_LOW_MIN;
    timing.response_high_min = RST_RESPONSE_HIGH_MIN;
    frame_phase = PH_IDLE;
    clear_frame();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_ignored_events();
    test_preamble_errors();
    src_pauses  = 1'b1;
    sink_pauses = 1'b1;
    test_bit_errors();
    test_frame_values();
    test_backpressure();
    test_random_traffic();

    @(negedge clk);
    in_valid = 1'b0;
    repeat (10) @(posedge clk);
    if (pending_readings.size() != 0)
      error_count += pending_readings.size();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
